FILE: src/rational_arith_unit_defines.svh
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// clocked assertion, off during reset
`ifndef ASSERT_OFF
`define RAU_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("rational_arith_unit assertion failed");
`define RAU_ASSERT_IMP(label, pre, post) \
	`RAU_ASSERT(label, (pre) |-> (post))
`else
`define RAU_ASSERT(label, prop)
`define RAU_ASSERT_IMP(label, pre, post)
`endif

`endif

FILE: src/rau_pkg.sv
package rau_pkg;

	localparam int FUNC_BITS = 3;

	localparam logic [FUNC_BITS-1:0] FN_ADD = 3'd0;
	localparam logic [FUNC_BITS-1:0] FN_SUB = 3'd1;
	localparam logic [FUNC_BITS-1:0] FN_MUL = 3'd2;
	localparam logic [FUNC_BITS-1:0] FN_DIV = 3'd3;
	localparam logic [FUNC_BITS-1:0] FN_ABS = 3'd4;
	localparam logic [FUNC_BITS-1:0] FN_POW = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M0,
		S_M1,
		S_M2,
		S_PW,
		S_RED,
		S_GCHK,
		S_GCD,
		S_QN,
		S_QD,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_RN,
		PH_RD,
		PH_BN,
		PH_BD
	} phase_t;

endpackage

FILE: src/rau_req_if.sv
interface rau_req_if #(
	parameter int WORD_BITS = 16
);
	logic                           valid;
	logic                           ready;
	logic [rau_pkg::FUNC_BITS-1:0]  func;
	logic signed [WORD_BITS-1:0]    x_num;
	logic signed [WORD_BITS-1:0]    x_den;
	logic signed [WORD_BITS-1:0]    y_num;
	logic signed [WORD_BITS-1:0]    y_den;
	logic signed [WORD_BITS-1:0]    power;

	modport source (output valid, func, x_num, x_den, y_num, y_den, power, input ready);
	modport sink (input valid, func, x_num, x_den, y_num, y_den, power, output ready);
endinterface

FILE: src/rau_rsp_if.sv
interface rau_rsp_if #(
	parameter int WORD_BITS = 16
);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] res_num;
	logic signed [WORD_BITS-1:0] res_den;

	modport source (output valid, res_num, res_den, input ready);
	modport sink (input valid, res_num, res_den, output ready);
endinterface

FILE: src/rau_div.sv
module rau_div #(
	parameter int WORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] dividend,
	input  logic [WORD_BITS-1:0] divisor,
	output logic                 done,
	output logic [WORD_BITS-1:0] quot,
	output logic [WORD_BITS-1:0] rem
);
	localparam int CW = $clog2(WORD_BITS + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [WORD_BITS:0]   rem_q;
	logic [WORD_BITS-1:0] quo_q;
	logic [WORD_BITS-1:0] dvs_q;
	logic [WORD_BITS:0]   shifted;
	logic [WORD_BITS:0]   diff;
	logic                 ge;

	// one restoring shift-subtract step per cycle
	assign shifted = {rem_q[WORD_BITS-1:0], quo_q[WORD_BITS-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = !diff[WORD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WORD_BITS-2:0], ge};
			rem_q <= ge ? diff : shifted;
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q[WORD_BITS-1:0];

endmodule

FILE: src/rational_arith_unit.sv
// channel  dir  handshake     payload
// req      in   valid/ready   func, x_num, x_den, y_num, y_den, power
// rsp      out  valid/ready   res_num, res_den
//
// one request at a time; req.ready is high only while idle, reset returns to idle
// products on one multiplier: mul and div in states M0 and M1, add and sub
// also in M2, power in phases RN, RD, BN, BD per exponent bit; absolute skips them
// reduction: gcd steps, then the two final divisions, on one shift-subtract
// divider; zero numerators and unused codes skip it
// a finished result waits in the output register; the next request is accepted
// meanwhile and stalls before its own result only if rsp is still held
`include "rational_arith_unit_defines.svh"

module rational_arith_unit #(
	parameter int WORD_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rau_req_if.sink   req,
	rau_rsp_if.source rsp
);
	import rau_pkg::*;

	localparam int W = WORD_BITS;

	state_t state_q, state_d;
	phase_t ph_q;

	logic [FUNC_BITS-1:0] func_q;
	logic [W-1:0] xn_q, xd_q, yn_q, yd_q;
	logic [W-1:0] n_q, d_q, t_q, bn_q, bd_q, e_q;
	logic [W-1:0] mn_q, md_q, ga_q, gb_q, rn_q, rd_q;
	logic         neg_q, fpos_q;
	logic [W-1:0] res_num_q, res_den_q;
	logic         rsp_valid_q;

	logic [W-1:0]   ma, mb, prod;
	logic [2*W-1:0] prod_full;
	logic [W-1:0]   mag_n, mag_d;
	logic [W-1:0]   pw_mag;
	logic           div_start, div_done;
	logic [W-1:0]   div_a, div_b, div_quot, div_rem;
	logic           out_free;

	rau_div #(.WORD_BITS(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign prod_full = ma * mb;
	assign prod      = prod_full[W-1:0];
	assign mag_n     = n_q[W-1] ? (~n_q + 1'b1) : n_q;
	assign mag_d     = d_q[W-1] ? (~d_q + 1'b1) : d_q;
	assign pw_mag    = req.power[W-1] ? (~req.power + 1'b1) : req.power;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		ma        = xd_q;
		mb        = yd_q;
		div_start = 1'b0;
		div_a     = ga_q;
		div_b     = gb_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.func)
						FN_ADD, FN_SUB, FN_MUL, FN_DIV: state_d = S_M0;
						FN_ABS: state_d = S_RED;
						FN_POW: state_d = S_PW;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_M0: begin
				ma = xn_q;
				mb = (func_q == FN_MUL) ? yn_q : yd_q;
				state_d = S_M1;
			end
			S_M1: begin
				ma = xd_q;
				mb = (func_q == FN_MUL) ? yd_q : yn_q;
				state_d = (func_q inside {FN_ADD, FN_SUB}) ? S_M2 : S_RED;
			end
			S_M2: begin
				state_d = S_RED;
			end
			S_PW: begin
				case (ph_q)
					PH_RN: begin
						ma = n_q;
						mb = bn_q;
					end
					PH_RD: begin
						ma = d_q;
						mb = bd_q;
					end
					PH_BN: begin
						ma = bn_q;
						mb = bn_q;
					end
					default: begin
						ma = bd_q;
						mb = bd_q;
					end
				endcase
				if (e_q == '0) begin
					state_d = S_RED;
				end
			end
			S_RED: begin
				state_d = (n_q == '0) ? S_DONE : S_GCHK;
			end
			S_GCHK: begin
				div_start = 1'b1;
				if (gb_q != '0) begin
					state_d = S_GCD;
				end else begin
					div_a   = mn_q;
					div_b   = ga_q;
					state_d = S_QN;
				end
			end
			S_GCD: begin
				if (div_done) begin
					state_d = S_GCHK;
				end
			end
			S_QN: begin
				div_a = md_q;
				div_b = ga_q;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = S_QD;
				end
			end
			S_QD: begin
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= req.func;
				xn_q   <= req.x_num;
				xd_q   <= req.x_den;
				yn_q   <= req.y_num;
				yd_q   <= req.y_den;
				fpos_q <= (req.func == FN_ABS);
				ph_q   <= PH_RN;
				// n/d start as x for absolute, 1/1 for power, 0/1 for unknown codes
				n_q    <= (req.func == FN_ABS) ? req.x_num : W'(req.func == FN_POW);
				d_q    <= (req.func == FN_ABS) ? req.x_den : W'(1);
				rn_q   <= '0;
				rd_q   <= W'(1);
				neg_q  <= 1'b0;
				e_q    <= pw_mag;
				if (req.power[W-1]) begin
					bn_q <= req.x_den;
					bd_q <= req.x_num;
				end else begin
					bn_q <= req.x_num;
					bd_q <= req.x_den;
				end
			end
			S_M0: n_q <= prod;
			S_M1: begin
				if (func_q inside {FN_ADD, FN_SUB}) begin
					t_q <= prod;
				end else begin
					d_q <= prod;
				end
			end
			S_M2: begin
				d_q <= prod;
				n_q <= (func_q == FN_SUB) ? (n_q - t_q) : (n_q + t_q);
			end
			S_PW: begin
				if (e_q != '0) begin
					case (ph_q)
						PH_RN: begin
							if (e_q[0]) n_q <= prod;
							ph_q <= PH_RD;
						end
						PH_RD: begin
							if (e_q[0]) d_q <= prod;
							ph_q <= PH_BN;
						end
						PH_BN: begin
							bn_q <= prod;
							ph_q <= PH_BD;
						end
						default: begin
							bd_q <= prod;
							e_q  <= e_q >> 1;
							ph_q <= PH_RN;
						end
					endcase
				end
			end
			S_RED: begin
				neg_q <= !fpos_q && (n_q[W-1] != d_q[W-1]);
				mn_q  <= mag_n;
				md_q  <= mag_d;
				ga_q  <= mag_n;
				gb_q  <= mag_d;
			end
			S_GCD: begin
				if (div_done) begin
					ga_q <= gb_q;
					gb_q <= div_rem;
				end
			end
			S_QN: if (div_done) rn_q <= div_quot;
			S_QD: if (div_done) rd_q <= div_quot;
			S_DONE: begin
				if (out_free) begin
					res_num_q <= neg_q ? (~rn_q + 1'b1) : rn_q;
					res_den_q <= rd_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.res_num = res_num_q;
	assign rsp.res_den = res_den_q;

	// divider finishes only while a division is awaited
	`RAU_ASSERT_IMP(a_div_done_expected, div_done,
		state_q == S_GCD || state_q == S_QN || state_q == S_QD)
	// gcd is never zero when the quotients start
	`RAU_ASSERT_IMP(a_gcd_nonzero, state_q == S_GCHK && gb_q == '0, ga_q != '0)
	// a new result appears only out of the done state
	`RAU_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_q), $past(state_q) == S_DONE)
	// zero numerator always carries a unit denominator
	`RAU_ASSERT_IMP(a_zero_over_one, rsp_valid_q && res_num_q == '0, res_den_q == W'(1))

endmodule

FILE: tb/tb.sv
module tb;
	import rau_pkg::*;

	localparam int W = 16;
	localparam int LIMIT = 4000000;

	typedef logic signed [W-1:0] word_t;

	typedef struct {
		logic [FUNC_BITS-1:0] func;
		word_t xn, xd, yn, yd, pw;
	} op_t;

	typedef struct {
		word_t num, den;
	} frac_t;

	class frac_scoreboard;
		frac_t pending[$];
		int errors;
		int checked;

		function frac_t reduce(logic [W-1:0] n, logic [W-1:0] d, bit force_pos);
			frac_t r;
			longint sn, sd;
			longint unsigned mn, md, a, b, t, rn, rd;
			bit neg;
			sn = $signed(n);
			sd = $signed(d);
			if (sn == 0) begin
				r.num = 0;
				r.den = 1;
				return r;
			end
			neg = force_pos ? 0 : ((sn < 0) != (sd < 0));
			mn = sn < 0 ? -sn : sn;
			md = sd < 0 ? -sd : sd;
			a = mn;
			b = md;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			rn = mn / a;
			rd = md / a;
			r.num = neg ? word_t'(0 - rn) : word_t'(rn);
			r.den = word_t'(rd);
			return r;
		endfunction

		function frac_t compute(op_t op);
			frac_t r;
			logic [W-1:0] n, d, bn, bd, pn, pd;
			int e;
			case (op.func)
				FN_ADD: r = reduce(op.xn * op.yd + op.xd * op.yn, op.xd * op.yd, 0);
				FN_SUB: r = reduce(op.xn * op.yd - op.xd * op.yn, op.xd * op.yd, 0);
				FN_MUL: r = reduce(op.xn * op.yn, op.xd * op.yd, 0);
				FN_DIV: r = reduce(op.xn * op.yd, op.xd * op.yn, 0);
				FN_ABS: r = reduce(op.xn, op.xd, 1);
				FN_POW: begin
					if (op.pw == 0) begin
						r.num = 1;
						r.den = 1;
					end else begin
						bn = op.pw < 0 ? op.xd : op.xn;
						bd = op.pw < 0 ? op.xn : op.xd;
						e = op.pw < 0 ? -int'(op.pw) : int'(op.pw);
						pn = 1;
						pd = 1;
						while (e != 0) begin
							if (e & 1) begin
								pn = pn * bn;
								pd = pd * bd;
							end
							bn = bn * bn;
							bd = bd * bd;
							e = e >> 1;
						end
						r = reduce(pn, pd, 0);
					end
				end
				default: begin
					r.num = 0;
					r.den = 1;
				end
			endcase
			return r;
		endfunction

		function void note_request(op_t op);
			pending.push_back(compute(op));
		endfunction

		function void check_result(word_t num, word_t den);
			frac_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d", $time, num, den);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (num !== e.num) begin
				$display("%0t: res_num expected %0d actual %0d", $time, e.num, num);
				errors++;
			end
			if (den !== e.den) begin
				$display("%0t: res_den expected %0d actual %0d", $time, e.den, den);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	int cycles = 0;
	bit stim_done = 0;
	int long_hold = 0;
	frac_scoreboard sb;

	rau_req_if #(.WORD_BITS(W)) req ();
	rau_rsp_if #(.WORD_BITS(W)) rsp ();

	rational_arith_unit #(.WORD_BITS(W)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		req.valid = 0;
		req.func = 0;
		req.x_num = 0;
		req.x_den = 0;
		req.y_num = 0;
		req.y_den = 0;
		req.power = 0;
		rsp.ready = 0;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function word_t rand_word();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
			1: return word_t'($signed($urandom_range(0, 2)) - 1);
			2: return word_t'($signed($urandom_range(0, 40)) - 20);
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic send(op_t op);
		int gap;
		gap = $urandom_range(0, 11);
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1;
		req.func <= op.func;
		req.x_num <= op.xn;
		req.x_den <= op.xd;
		req.y_num <= op.yn;
		req.y_den <= op.yd;
		req.power <= op.pw;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op);
	endtask

	task automatic send_one(logic [2:0] f, word_t xn, xd, yn, yd, pw);
		op_t op;
		op.func = f;
		op.xn = xn;
		op.xd = xd;
		op.yn = yn;
		op.yd = yd;
		op.pw = pw;
		send(op);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// result side: random stall per result, plus one long hold-off
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (long_hold > 0) begin
				rsp.ready <= 0;
				repeat (long_hold) @(posedge clk);
				long_hold = 0;
			end
			stall = $urandom_range(0, 11);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				rsp.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1;
			do @(posedge clk); while (!rsp.valid);
			sb.check_result(rsp.res_num, rsp.res_den);
		end
	end

	initial begin
		op_t op;
		int wait_cnt;
		@(posedge arst_n);
		@(posedge clk);
		// directed corners
		send_one(FN_ADD, 1, 2, 1, 3, 0);
		send_one(FN_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
		send_one(FN_SUB, 1, 2, 1, 2, 0);
		send_one(FN_SUB, -16'sd32768, 1, 1, 1, 0);
		send_one(FN_MUL, -16'sd32768, 1, 1, 1, 0);
		send_one(FN_MUL, 3, 4, -4, 3, 0);
		send_one(FN_DIV, 1, 2, 0, 5, 0);
		send_one(FN_DIV, -3, 7, 2, -5, 0);
		send_one(FN_ABS, -5, 10, 0, 0, 0);
		send_one(FN_ABS, 5, -10, 0, 0, 0);
		send_one(FN_ABS, 0, 0, 0, 0, 0);
		send_one(FN_ABS, 7, 0, 0, 0, 0);
		send_one(FN_ABS, -16'sd32768, 1, 0, 0, 0);
		send_one(FN_ABS, -16'sd32768, -16'sd32768, 0, 0, 0);
		send_one(FN_MUL, -7, 0, 1, 1, 0);
		send_one(FN_POW, 2, 3, 0, 0, 0);
		send_one(FN_POW, 2, 3, 0, 0, 3);
		send_one(FN_POW, 2, 3, 0, 0, -3);
		send_one(FN_POW, 3, -2, 0, 0, 16'sh7fff);
		send_one(FN_POW, -1, 1, 0, 0, -16'sd32768);
		send_one(FN_POW, 0, 5, 0, 0, -2);
		send_one(3'd6, 1, 1, 1, 1, 1);
		send_one(3'd7, -1, -1, -1, -1, -1);
		drain();
		// receiver stalls long while sender keeps offering
		long_hold = 400;
		for (int i = 0; i < 650; i++) begin
			op.func = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			op.xn = rand_word();
			op.xd = rand_word();
			op.yn = rand_word();
			op.yd = rand_word();
			op.pw = $urandom_range(0, 3) == 0 ? rand_word()
				: word_t'($signed($urandom_range(0, 20)) - 10);
			send(op);
			if (i == 300) drain();
		end
		drain();
		wait_cnt = 0;
		while (wait_cnt < 2000) begin
			@(posedge clk);
			wait_cnt++;
		end
		$display("checked %0d results over add, sub, mul, div, abs, power and unused codes",
			sb.checked);
		$display("corners of word range, zero parts and long result stalls included");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
